>>> rtl/rcba_pkg.sv
// Shared constants, codes and descriptor types of the ring chunk buffer allocator.
package rcba_pkg;

  localparam int MEM_BYTES   = 131072;
  localparam int QUEUE_DEPTH = 64;

  localparam int SIZE_W = 18;
  localparam int TAG_W  = 32;
  localparam int SEQ_W  = 32;
  localparam int PTR_W  = $clog2(MEM_BYTES);
  localparam int CNT_W  = PTR_W + 1;
  localparam int CALC_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_FIELDS_W  = SIZE_W + TAG_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = PTR_W + SIZE_W + TAG_W + SEQ_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FLAGS_W  = 4;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_BUSY  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_CHUNK = 6'b000100,
    ST_GET1  = 6'b001000,
    ST_GET2  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic              pad;
    logic [PTR_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } place_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
  } meta_t;

  localparam int PLACE_W = $bits(place_t);
  localparam int META_W  = $bits(meta_t);

endpackage

>>> rtl/rcba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ring_chunk_buffer_allocator.sv
// Ring chunk buffer allocator: descriptor queue in RAM, pointer and stash control.
// An add runs through PAD, CHUNK and DONE; a get through GET1 and DONE (straight to
// DONE on an empty queue, through GET1, GET2 and DONE when a leading padding
// descriptor is dropped before a chunk); a busy poll and a clear go straight to DONE
// (a busy poll on a stash retry through PAD, CHUNK and DONE). DONE waits for the
// output register to be free. One item is in work at a time; the next beat is taken
// the cycle after the result is loaded. Reset is synchronous and clears the state,
// pointers, counts, sequence, stash size and output valid; descriptor RAM is not cleared.
module ring_chunk_buffer_allocator
  import rcba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // chunk_size, format_tag
  input  logic [1:0]             in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // chunk_start, chunk_size_out, format_tag_out,
                                             // seq_index, free_bytes
  output logic [OUT_FLAGS_W-1:0] out_tuser   // stored, stashed, got_valid, busy_res
);

  localparam logic [CALC_W-1:0] MEM_C  = CALC_W'(MEM_BYTES);
  localparam logic [CALC_W-1:0] HALF_C = CALC_W'(MEM_BYTES / 2);
  localparam logic [QC_W-1:0]   DEPTH_C = QC_W'(QUEUE_DEPTH);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [QA_W-1:0]   head_r, head_nxt;
  logic [QC_W-1:0]   count_r, count_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [SIZE_W-1:0] stash_size_r, stash_size_nxt;
  logic [TAG_W-1:0]  stash_tag_r, stash_tag_nxt;

  logic [SIZE_W-1:0] plc_size_r, plc_size_nxt;
  logic [TAG_W-1:0]  plc_tag_r, plc_tag_nxt;
  logic              retry_r, retry_nxt;

  logic              res_stored_r, res_stored_nxt;
  logic              res_stashed_r, res_stashed_nxt;
  logic              res_got_r, res_got_nxt;
  logic              res_busy_r, res_busy_nxt;
  logic [PTR_W-1:0]  res_start_r, res_start_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;
  logic [TAG_W-1:0]  res_tag_r, res_tag_nxt;
  logic [SEQ_W-1:0]  res_seq_r, res_seq_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_FLAGS_W-1:0]  out_flags_r, out_flags_nxt;
  logic [OUT_FIELDS_W-1:0] out_data_r, out_data_nxt;

  logic              in_acc;
  req_t              in_req;
  logic [SIZE_W-1:0] in_size;
  logic [TAG_W-1:0]  in_tag;

  logic [CALC_W-1:0] used_c;
  logic [CNT_W-1:0]  free_w;
  logic [CNT_W-1:0]  avail_w;
  logic [CNT_W-1:0]  tail_w;
  logic              fits_w;
  logic [QC_W:0]     idx_sum;
  logic [QA_W-1:0]   tail_idx;
  logic [QA_W-1:0]   head_inc;
  logic [CALC_W-1:0] rp_sum;
  logic [CALC_W-1:0] busy_sum;

  logic              ram_we;
  place_t            wr_place, rd_place;
  meta_t             wr_meta, rd_meta;

  assign in_acc  = in_tvalid && in_tready;
  assign in_req  = req_t'(in_tuser);
  assign in_size = in_tdata[SIZE_W-1:0];
  assign in_tag  = in_tdata[IN_FIELDS_W-1:SIZE_W];

  always_comb begin
    if (wp_r >= CNT_W'(rp_r)) begin
      if (wp_r == CNT_W'(rp_r)) begin
        used_c = CALC_W'(used_r);
      end else begin
        used_c = CALC_W'(wp_r) - CALC_W'(rp_r);
      end
    end else begin
      used_c = MEM_C - CALC_W'(rp_r) + CALC_W'(wp_r);
    end
    if (used_c > MEM_C) begin
      free_w = '0;
    end else begin
      free_w = CNT_W'(MEM_C - used_c);
    end
  end

  assign avail_w  = (count_r >= DEPTH_C) ? '0 : free_w;
  assign tail_w   = CNT_W'(MEM_C - CALC_W'(wp_r));
  assign fits_w   = CALC_W'(avail_w) >= CALC_W'(plc_size_r);
  assign idx_sum  = (QC_W + 1)'(head_r) + (QC_W + 1)'(count_r);
  assign tail_idx = (idx_sum >= (QC_W + 1)'(QUEUE_DEPTH)) ?
                    QA_W'(idx_sum - (QC_W + 1)'(QUEUE_DEPTH)) : QA_W'(idx_sum);
  assign head_inc = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign rp_sum   = CALC_W'(rp_r) + CALC_W'(rd_place.size);
  assign busy_sum = CALC_W'(used_r) + CALC_W'(stash_size_r);

  always_comb begin
    state_nxt       = state_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    used_nxt        = used_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    seq_nxt         = seq_r;
    stash_size_nxt  = stash_size_r;
    stash_tag_nxt   = stash_tag_r;
    plc_size_nxt    = plc_size_r;
    plc_tag_nxt     = plc_tag_r;
    retry_nxt       = retry_r;
    res_stored_nxt  = res_stored_r;
    res_stashed_nxt = res_stashed_r;
    res_got_nxt     = res_got_r;
    res_busy_nxt    = res_busy_r;
    res_start_nxt   = res_start_r;
    res_size_nxt    = res_size_r;
    res_tag_nxt     = res_tag_r;
    res_seq_nxt     = res_seq_r;
    out_valid_nxt   = out_valid_r;
    out_flags_nxt   = out_flags_r;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    wr_place        = '{pad: 1'b0, start: wp_r[PTR_W-1:0], size: plc_size_r};
    wr_meta         = '{tag: plc_tag_r, seq: seq_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_stored_nxt  = 1'b0;
          res_stashed_nxt = 1'b0;
          res_got_nxt     = 1'b0;
          res_busy_nxt    = 1'b0;
          res_start_nxt   = '0;
          res_size_nxt    = '0;
          res_tag_nxt     = '0;
          res_seq_nxt     = '0;
          retry_nxt       = 1'b0;
          plc_size_nxt    = in_size;
          plc_tag_nxt     = in_tag;
          case (in_req)
            REQ_ADD: begin
              state_nxt = ST_PAD;
            end
            REQ_GET: begin
              state_nxt = (count_r != '0) ? ST_GET1 : ST_DONE;
            end
            REQ_BUSY: begin
              state_nxt = ST_DONE;
              if (busy_sum > MEM_C) begin
                res_busy_nxt = 1'b1;
              end else if (stash_size_r != '0 && CALC_W'(free_w) > HALF_C) begin
                plc_size_nxt = stash_size_r;
                plc_tag_nxt  = stash_tag_r;
                retry_nxt    = 1'b1;
                state_nxt    = ST_PAD;
              end else begin
                res_busy_nxt = stash_size_r != '0;
              end
            end
            REQ_CLEAR: begin
              head_nxt       = '0;
              count_nxt      = '0;
              rp_nxt         = '0;
              wp_nxt         = '0;
              used_nxt       = '0;
              stash_size_nxt = '0;
              state_nxt      = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_PAD: begin
        if (fits_w && CALC_W'(tail_w) < CALC_W'(plc_size_r)) begin
          ram_we    = 1'b1;
          wr_place  = '{pad: 1'b1, start: wp_r[PTR_W-1:0], size: SIZE_W'(tail_w)};
          wr_meta   = '0;
          count_nxt = count_r + 1'b1;
          used_nxt  = used_r + tail_w;
          wp_nxt    = '0;
        end
        state_nxt = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (fits_w) begin
          // full queue: a zero-size chunk still counts as stored, drop its descriptor
          if (count_r < DEPTH_C) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          res_stored_nxt = 1'b1;
          res_start_nxt  = wp_r[PTR_W-1:0];
          res_size_nxt   = plc_size_r;
          res_tag_nxt    = plc_tag_r;
          res_seq_nxt    = seq_r;
          seq_nxt        = seq_r + 1'b1;
          used_nxt       = CNT_W'(CALC_W'(used_r) + CALC_W'(plc_size_r));
          wp_nxt         = CNT_W'(CALC_W'(wp_r) + CALC_W'(plc_size_r));
        end else if (!retry_r) begin
          stash_size_nxt  = plc_size_r;
          stash_tag_nxt   = plc_tag_r;
          res_stashed_nxt = plc_size_r != '0;
        end
        if (retry_r) begin
          stash_size_nxt = '0;
        end
        state_nxt = ST_DONE;
      end
      ST_GET1, ST_GET2: begin
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
        rp_nxt    = (rp_sum >= MEM_C) ? '0 : rp_sum[PTR_W-1:0];
        used_nxt  = (CALC_W'(used_r) >= CALC_W'(rd_place.size)) ?
                    CNT_W'(CALC_W'(used_r) - CALC_W'(rd_place.size)) : '0;
        if (state_r == ST_GET1 && rd_place.pad) begin
          state_nxt = (count_r != QC_W'(1)) ? ST_GET2 : ST_DONE;
        end else begin
          res_got_nxt   = 1'b1;
          res_start_nxt = rd_place.start;
          res_size_nxt  = rd_place.size;
          res_tag_nxt   = rd_meta.tag;
          res_seq_nxt   = rd_meta.seq;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_flags_nxt = {res_busy_r, res_got_r, res_stashed_r, res_stored_r};
          out_data_nxt  = {free_w, res_seq_r, res_tag_r, res_size_r, res_start_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      rp_r         <= '0;
      used_r       <= '0;
      head_r       <= '0;
      count_r      <= '0;
      seq_r        <= '0;
      stash_size_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      used_r       <= used_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      seq_r        <= seq_nxt;
      stash_size_r <= stash_size_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stash_tag_r   <= stash_tag_nxt;
    plc_size_r    <= plc_size_nxt;
    plc_tag_r     <= plc_tag_nxt;
    retry_r       <= retry_nxt;
    res_stored_r  <= res_stored_nxt;
    res_stashed_r <= res_stashed_nxt;
    res_got_r     <= res_got_nxt;
    res_busy_r    <= res_busy_nxt;
    res_start_r   <= res_start_nxt;
    res_size_r    <= res_size_nxt;
    res_tag_r     <= res_tag_nxt;
    res_seq_r     <= res_seq_nxt;
    out_flags_r   <= out_flags_nxt;
    out_data_r    <= out_data_nxt;
  end

  rcba_ram #(
    .WIDTH (PLACE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_place_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (wr_place),
    .raddr (head_nxt),
    .rdata (rd_place)
  );

  rcba_ram #(
    .WIDTH (META_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_meta_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (wr_meta),
    .raddr (head_nxt),
    .rdata (rd_meta)
  );

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_flags_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("descriptor count above queue depth");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= CNT_W'(MEM_BYTES))
    else $error("write pointer beyond ring end");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < DEPTH_C)
    else $error("descriptor push into full queue");

  a_get_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GET1 || state_r == ST_GET2) |-> count_r != '0)
    else $error("descriptor pop from empty queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second beat taken while an item is in work");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_flags_r))
    else $error("more than one result flag set");

endmodule
